@@ rtl/bpmc_pkg.sv @@
// shared types, constants and the per-byte position step for the pattern match counter
`timescale 1ns / 1ps

package bpmc_pkg;

	localparam int PatternLen = 17;
	localparam int LaneCount = 4;
	localparam int ByteW = 8;
	localparam int WordW = LaneCount * ByteW;
	localparam int CountW = 32;
	localparam int PosW = 5;
	localparam int CfgW = 64;
	localparam int CfgIdxW = 2;

	typedef logic [PosW-1:0] pos_t;
	typedef logic [PatternLen-1:0] hit_vec_t;
	typedef logic [PatternLen-1:0][ByteW-1:0] pattern_t;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_PAT_LOW  = 2'd0,
		CFG_PAT_MID  = 2'd1,
		CFG_PAT_LAST = 2'd2
	} cfg_reg_t;

	// hit vectors of one word, lane 0 is the byte scanned first
	typedef struct packed {
		logic valid;
		logic last;
		logic [LaneCount-1:0][PatternLen-1:0] hits;
	} scan_req_t;

	typedef struct packed {
		logic done;
		pos_t pos;
	} step_t;

	// one byte of the match walk: hit advances, miss drops to zero
	function automatic step_t scan_step(pos_t pos, hit_vec_t hits);
		step_t st;
		st.done = 1'b0;
		st.pos = '0;
		if (pos < PosW'(PatternLen) && hits[pos]) begin
			if (pos == PosW'(PatternLen - 1)) begin
				st.done = 1'b1;
			end else begin
				st.pos = pos + PosW'(1);
			end
		end
		return st;
	endfunction

endpackage

@@ rtl/bpmc_lane.sv @@
// one byte lane: compares its byte with every pattern byte at once
`timescale 1ns / 1ps

module bpmc_lane (
	input  logic [bpmc_pkg::ByteW-1:0] data_byte,
	input  bpmc_pkg::pattern_t         pattern,
	output bpmc_pkg::hit_vec_t         hits
);
	import bpmc_pkg::*;

	always_comb begin
		for (int p = 0; p < PatternLen; p++) begin
			hits[p] = (data_byte == pattern[p]);
		end
	end

endmodule

@@ rtl/bpmc_merge.sv @@
// merge stage: walks the match position through the lane hits and keeps the count
`timescale 1ns / 1ps

module bpmc_merge (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bpmc_pkg::scan_req_t         req_s1,
	output logic                        take,
	output logic                        count_valid,
	input  logic                        count_stall,
	output logic [bpmc_pkg::CountW-1:0] match_count
);
	import bpmc_pkg::*;

	pos_t              pos_q;
	logic [CountW-1:0] count_q;
	logic [CountW-1:0] count_next;
	logic [CountW-1:0] match_count_q;
	logic              count_valid_q;
	pos_t              pos_chain [LaneCount+1];
	logic              hit_done;
	step_t             st;

	// a full match needs 17 bytes, so one word finishes at most one
	always_comb begin
		pos_chain[0] = pos_q;
		hit_done = 1'b0;
		for (int k = 0; k < LaneCount; k++) begin
			st = scan_step(pos_chain[k], req_s1.hits[k]);
			pos_chain[k+1] = st.pos;
			hit_done = hit_done | st.done;
		end
		count_next = (hit_done && count_q != '1) ? count_q + CountW'(1) : count_q;
	end

	assign take = req_s1.valid && !(req_s1.last && count_valid_q && count_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			count_q <= '0;
			count_valid_q <= 1'b0;
		end else begin
			if (take && req_s1.last) begin
				count_valid_q <= 1'b1;
			end else if (!count_stall) begin
				count_valid_q <= 1'b0;
			end
			if (take) begin
				if (req_s1.last) begin
					pos_q <= '0;
					count_q <= '0;
				end else begin
					pos_q <= pos_chain[LaneCount];
					count_q <= count_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && req_s1.last) begin
			match_count_q <= count_next;
		end
	end

	assign count_valid = count_valid_q;
	assign match_count = match_count_q;

endmodule

@@ rtl/byte_pattern_match_counter_top.sv @@
// top level of the streaming 17-byte pattern match counter
`timescale 1ns / 1ps

// a count is registered once the merge stage takes its last word from the stage one register
// throughput: one 32-bit word per cycle unless stalled, four byte lanes compare in parallel
// a last word holds the input only while the previous count is still stalled
// the byte-to-byte position walk is combinational in the merge stage
// reset clears pattern registers, match position, count and both valid flags
// a new region starts after each last word; state carries across words otherwise

module byte_pattern_match_counter_top (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration writes
	input  logic                          cfg_we,
	input  logic [bpmc_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [bpmc_pkg::CfgW-1:0]     cfg_data,
	// word requests
	input  logic                          word_valid,
	output logic                          word_stall,
	input  logic [bpmc_pkg::WordW-1:0]    stream_word,
	input  logic                          last_word,
	// count results
	output logic                          count_valid,
	input  logic                          count_stall,
	output logic [bpmc_pkg::CountW-1:0]   match_count
);
	import bpmc_pkg::*;

	// pattern registers
	logic [CfgW-1:0]  pat_low_q;
	logic [CfgW-1:0]  pat_mid_q;
	logic [ByteW-1:0] pat_last_q;
	pattern_t         pattern;

	// lane outputs and stage one
	hit_vec_t  lane_hits [LaneCount];
	scan_req_t req_s1;
	logic      accept;
	logic      take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q <= '0;
			pat_mid_q <= '0;
			pat_last_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_PAT_LOW: begin
					pat_low_q <= cfg_data;
				end
				CFG_PAT_MID: begin
					pat_mid_q <= cfg_data;
				end
				CFG_PAT_LAST: begin
					pat_last_q <= cfg_data[ByteW-1:0];
				end
				default: begin
					// unused index, write dropped
				end
			endcase
		end
	end

	// flatten to one byte per pattern position
	always_comb begin
		for (int p = 0; p < 8; p++) begin
			pattern[p] = pat_low_q[p*ByteW +: ByteW];
			pattern[p+8] = pat_mid_q[p*ByteW +: ByteW];
		end
		pattern[PatternLen-1] = pat_last_q;
	end

	// byte lanes, lane 0 takes bits 7..0
	for (genvar k = 0; k < LaneCount; k++) begin : g_lane
		bpmc_lane u_lane (
			.data_byte (stream_word[k*ByteW +: ByteW]),
			.pattern   (pattern),
			.hits      (lane_hits[k])
		);
	end

	// stage one holds while the merge stage cannot take it
	assign word_stall = req_s1.valid && !take;
	assign accept = word_valid && !word_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_s1 <= '0;
		end else if (accept) begin
			req_s1.valid <= 1'b1;
			req_s1.last <= last_word;
			for (int k = 0; k < LaneCount; k++) begin
				req_s1.hits[k] <= lane_hits[k];
			end
		end else if (take) begin
			req_s1.valid <= 1'b0;
		end
	end

	// position walk, saturating count and the result register
	bpmc_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_s1      (req_s1),
		.take        (take),
		.count_valid (count_valid),
		.count_stall (count_stall),
		.match_count (match_count)
	);

endmodule

@@ dv/tb_byte_pattern_match_counter_top.sv @@
// testbench for the streaming 17-byte pattern match counter: random requests, self-checking counts
`timescale 1ns / 1ps

module tb_byte_pattern_match_counter_top;
	import bpmc_pkg::*;

	localparam int WatchdogLimit = 2000;   // cycles with no handshake before giving up
	localparam int DrainCycles = 4;        // extra cycles to work off words that owe no count
	localparam int LongHold = 80;          // receiver back-pressure long enough to fill the block
	localparam int MaxGap = 12;
	localparam int PhaseWords = 118;
	localparam int PressureWords = 80;
	localparam int PressurePhase = 4;
	localparam logic [CfgIdxW-1:0] CFG_IDX_UNUSED = 2'd3;

	typedef struct packed {
		logic [WordW-1:0] word;
		logic             last;
	} word_req_t;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [CfgW-1:0]     cfg_data = '0;
	logic                word_valid = 1'b0;
	logic                word_stall;
	logic [WordW-1:0]    stream_word = '0;
	logic                last_word = 1'b0;
	logic                count_valid;
	logic                count_stall = 1'b0;
	logic [CountW-1:0]   match_count;

	// pattern registers as the block should hold them
	logic [CfgW-1:0]     pat_low_m = '0;
	logic [CfgW-1:0]     pat_mid_m = '0;
	logic [ByteW-1:0]    pat_last_m = '0;
	// match walk state carried across words of a region
	pos_t                scan_pos = '0;
	logic [CountW-1:0]   region_count = '0;

	word_req_t           word_queue[$];      // requests not yet offered
	logic [CountW-1:0]   count_expect_q[$];  // counts owed by the block, oldest first
	logic [ByteW-1:0]    byte_q[$];          // stream bytes waiting to be packed into words
	int unsigned         queued_words = 0;
	int unsigned         mismatch_count = 0;

	// handshake bookkeeping
	word_req_t           next_req;
	logic [CountW-1:0]   expected_count;
	bit                  word_taken = 1'b0;
	int unsigned         send_gap = 0;
	int unsigned         recv_hold = 0;
	bit                  send_steady = 1'b0;
	bit                  recv_steady = 1'b0;
	bit                  send_rush = 1'b0;
	bit                  long_hold_req = 1'b0;
	int unsigned         long_hold_left = 0;
	int unsigned         idle_cycles = 0;

	byte_pattern_match_counter_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.word_valid  (word_valid),
		.word_stall  (word_stall),
		.stream_word (stream_word),
		.last_word   (last_word),
		.count_valid (count_valid),
		.count_stall (count_stall),
		.match_count (match_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// pattern byte at a match position, from the modeled registers
	function automatic logic [ByteW-1:0] pattern_byte(int unsigned pos);
		if (pos < 8)
			return pat_low_m[ByteW*pos +: ByteW];
		if (pos < 16)
			return pat_mid_m[ByteW*(pos-8) +: ByteW];
		return pat_last_m;
	endfunction

	// walk the four bytes of one word, lane 0 first; a last word owes its count
	function automatic void count_word(logic [WordW-1:0] word, logic last);
		logic [ByteW-1:0] b;
		for (int k = 0; k < LaneCount; k++) begin
			b = word[ByteW*k +: ByteW];
			if (b == pattern_byte(scan_pos)) begin
				if (scan_pos == PosW'(PatternLen - 1)) begin
					// full match: count saturates, walk restarts
					scan_pos = '0;
					if (region_count != '1)
						region_count++;
				end else begin
					scan_pos++;
				end
			end else begin
				// a miss is not compared again against the first pattern byte
				scan_pos = '0;
			end
		end
		if (last) begin
			count_expect_q.push_back(region_count);
			region_count = '0;
			scan_pos = '0;
		end
	endfunction

	task automatic queue_word(logic [WordW-1:0] w, logic last);
		word_queue.push_back('{w, last});
		queued_words++;
	endtask

	task automatic push_pattern(int unsigned from_pos, int unsigned to_pos);
		for (int unsigned i = from_pos; i < to_pos; i++)
			byte_q.push_back(pattern_byte(i));
	endtask

	task automatic push_noise(int unsigned n);
		repeat (n) byte_q.push_back(ByteW'($urandom));
	endtask

	// pad the byte stream to whole words and queue them
	task automatic emit_words(bit mark_last);
		logic [WordW-1:0] w;
		while (byte_q.size() == 0 || byte_q.size() % LaneCount != 0)
			byte_q.push_back(ByteW'($urandom));
		while (byte_q.size() > 0) begin
			for (int k = 0; k < LaneCount; k++)
				w[ByteW*k +: ByteW] = byte_q.pop_front();
			queue_word(w, mark_last && byte_q.size() == 0);
		end
	endtask

	// one region: mostly pattern copies in noise, some broken or abandoned ones
	task automatic build_region();
		int unsigned segs;
		int unsigned kind;
		int unsigned cut;
		if ($urandom_range(0, 5) == 0) begin
			// single-word region
			queue_word($urandom, 1'b1);
			return;
		end
		segs = $urandom_range(1, 4);
		repeat (segs) begin
			kind = $urandom_range(0, 9);
			if (kind <= 4) begin
				push_noise($urandom_range(0, 6));
				push_pattern(0, PatternLen);
			end else if (kind <= 6) begin
				// partial copy dropped right before a full one
				push_pattern(0, $urandom_range(1, PatternLen - 1));
				push_pattern(0, PatternLen);
			end else if (kind == 7) begin
				// one byte of the copy changed, usually breaking it
				cut = byte_q.size() + $urandom_range(0, PatternLen - 1);
				push_pattern(0, PatternLen);
				byte_q[cut] = byte_q[cut] ^ ByteW'($urandom_range(1, 255));
			end else if (kind == 8) begin
				push_noise($urandom_range(1, 12));
			end else begin
				// back-to-back copies
				repeat ($urandom_range(2, 3)) push_pattern(0, PatternLen);
			end
		end
		// now and then the region runs on into the next one
		emit_words($urandom_range(0, 7) != 0);
	endtask

	// register write, then the model follows; returns on a rising edge
	task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_PAT_LOW: pat_low_m = value;
			CFG_PAT_MID: pat_mid_m = value;
			CFG_PAT_LAST: pat_last_m = value[ByteW-1:0];
			default: ;  // unused index, block ignores it
		endcase
		@(posedge clk);
	endtask

	// all requests taken, all counts back, and words with no count worked off
	task automatic wait_drained();
		while (word_queue.size() != 0 || word_valid || count_expect_q.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	// word side: sample the handshake, predict on every accepted request
	always @(posedge clk) begin
		if (arst_n && word_valid && !word_stall) begin
			word_taken = 1'b1;
			count_word(stream_word, last_word);
		end
	end

	// word side: drive on the falling edge, hold a stalled request unchanged
	always @(negedge clk) begin
		if (!word_valid || word_taken) begin
			word_taken = 1'b0;
			if (send_gap > 0) begin
				send_gap--;
				word_valid <= 1'b0;
			end else if (word_queue.size() > 0) begin
				next_req = word_queue.pop_front();
				stream_word <= next_req.word;
				last_word <= next_req.last;
				word_valid <= 1'b1;
				// gap after this request; steady stretches run with none
				send_gap = (send_steady || send_rush) ? 0 : $urandom_range(0, MaxGap);
				if ($urandom_range(0, 29) == 0)
					send_steady = !send_steady;
			end else begin
				word_valid <= 1'b0;
			end
		end
	end

	// count side: compare each accepted count with the oldest owed one
	always @(posedge clk) begin
		if (arst_n && count_valid && !count_stall) begin
			if (count_expect_q.size() == 0) begin
				$display("%0t: unexpected count, expected none, actual %0d", $time, match_count);
				mismatch_count++;
			end else begin
				expected_count = count_expect_q.pop_front();
				if (match_count !== expected_count) begin
					$display("%0t: match_count mismatch, expected %0d, actual %0d",
						$time, expected_count, match_count);
					mismatch_count++;
				end
			end
			recv_hold = recv_steady ? 0 : $urandom_range(0, MaxGap);
			if ($urandom_range(0, 29) == 0)
				recv_steady = !recv_steady;
		end
	end

	// count side: stall drawn per count, plus one long hold on request
	always @(negedge clk) begin
		if (long_hold_req) begin
			long_hold_req = 1'b0;
			long_hold_left = LongHold;
		end
		if (long_hold_left > 0) begin
			long_hold_left--;
			count_stall <= 1'b1;
		end else if (recv_hold > 0) begin
			recv_hold--;
			count_stall <= 1'b1;
		end else begin
			count_stall <= 1'b0;
		end
	end

	// watchdog: too long without any handshake or register write
	always @(posedge clk) begin
		if ((word_valid && !word_stall) || (count_valid && !count_stall) || cfg_we)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WatchdogLimit) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int unsigned phase_start;
		logic [ByteW-1:0] fill;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset pattern is all zero bytes: a lone zero word finds nothing
		queue_word('0, 1'b1);
		// twenty zero bytes hold exactly one match
		repeat (4) queue_word('0, 1'b0);
		queue_word('0, 1'b1);
		queue_word('1, 1'b1);
		wait_drained();

		// every register, upper bits of the short one dropped, unused index ignored
		cfg_write(CFG_PAT_LOW, {$urandom, $urandom});
		cfg_write(CFG_PAT_MID, {$urandom, $urandom});
		cfg_write(CFG_PAT_LAST, {{(CfgW-ByteW){1'b1}}, ByteW'($urandom)});
		cfg_write(CFG_IDX_UNUSED, '1);
		// two copies starting on lane 1, matches finish mid-word and across words
		push_noise(1);
		push_pattern(0, PatternLen);
		push_pattern(0, PatternLen);
		emit_words(1'b1);
		wait_drained();

		// register change in the middle of an open region
		push_pattern(0, 12);
		emit_words(1'b0);
		wait_drained();
		cfg_write(CFG_PAT_MID, {$urandom, $urandom});
		push_pattern(12, PatternLen);
		emit_words(1'b1);
		wait_drained();

		// all-ones pattern against all-ones data
		cfg_write(CFG_PAT_LOW, '1);
		cfg_write(CFG_PAT_MID, '1);
		cfg_write(CFG_PAT_LAST, '1);
		repeat (4) queue_word('1, 1'b0);
		queue_word('1, 1'b1);

		// random phases, each under its own pattern
		// saturation of the count needs billions of matches and is out of reach here
		for (int phase = 0; phase < 8; phase++) begin
			wait_drained();
			fill = ByteW'($urandom);
			case (phase)
				1: begin
					// all-zero pattern
					cfg_write(CFG_PAT_LOW, '0);
					cfg_write(CFG_PAT_MID, '0);
					cfg_write(CFG_PAT_LAST, '0);
				end
				2: begin
					cfg_write(CFG_PAT_LOW, '1);
					cfg_write(CFG_PAT_MID, '1);
					cfg_write(CFG_PAT_LAST, '1);
				end
				3: begin
					// one byte value throughout
					cfg_write(CFG_PAT_LOW, {8{fill}});
					cfg_write(CFG_PAT_MID, {8{fill}});
					cfg_write(CFG_PAT_LAST, {8{fill}});
				end
				5: begin
					// leading byte repeated, so a miss often lands on a pattern start
					cfg_write(CFG_PAT_LOW, {$urandom, {4{fill}}});
					cfg_write(CFG_PAT_MID, {$urandom, $urandom});
					cfg_write(CFG_PAT_LAST, CfgW'(fill));
				end
				7: begin
					// only the low register changes
					cfg_write(CFG_PAT_LOW, {$urandom, $urandom});
				end
				default: begin
					cfg_write(CFG_PAT_LOW, {$urandom, $urandom});
					cfg_write(CFG_PAT_MID, {$urandom, $urandom});
					cfg_write(CFG_PAT_LAST, {$urandom, $urandom});
					if (phase == 6)
						cfg_write(CFG_IDX_UNUSED, {$urandom, $urandom});
				end
			endcase

			if (phase == PressurePhase) begin
				// counts on every word at full rate while the receiver holds off
				send_rush = 1'b1;
				long_hold_req = 1'b1;
				repeat (PressureWords) queue_word($urandom, 1'b1);
				wait_drained();
				send_rush = 1'b0;
			end else begin
				phase_start = queued_words;
				while (queued_words - phase_start < PhaseWords)
					build_region();
				// close any region left open so the next pattern starts clean
				if (!word_queue[$].last)
					queue_word($urandom, 1'b1);
			end
		end

		wait_drained();
		if (mismatch_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
